// ===== rtl/core/scfr_pkg.sv =====
// package: constants, codes and types for the sum-checked frame receiver
`default_nettype none

package scfr_pkg;

   // frame store geometry
   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // stream widths
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 16;
   localparam int PIDX_W     = 6;
   localparam int STATUS_W   = 2;
   localparam int RSP_FLD_W  = 4 * BYTE_W + LEN_W - BYTE_W + PIDX_W;
   localparam int RSP_DATA_W = ((RSP_FLD_W + 7) / 8) * 8;

   // frame format
   localparam logic [BYTE_W-1:0] HDR_SYNC0  = 8'h53;
   localparam logic [BYTE_W-1:0] HDR_SYNC1  = 8'h59;
   localparam logic [BYTE_W-1:0] TAIL_SYNC0 = 8'h54;
   localparam logic [BYTE_W-1:0] TAIL_SYNC1 = 8'h43;
   localparam int MIN_FRAME     = 10;
   localparam int FIRST_PAYLOAD = 6;
   localparam int HDR_BYTES     = 6;

   typedef enum logic [STATUS_W-1:0] {
      ST_PAYLOAD  = 2'd0,
      ST_SUM_ERR  = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_LOAD
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/sum_checked_frame_receiver.sv =====
// sum-checked frame receiver: frame store, checksum check and payload readout
// results: a status result is valid in the cycle after its transaction; a good
//   frame's payload results pass the READ and LOAD states and the output register,
//   then one per cycle while the result channel is free, from the single read port
// throughput: one byte per cycle in idle with the result channel free; none in readout
// reset: synchronous, clears fill count, sum, state and output valid; store undefined
`default_nettype none

module sum_checked_frame_receiver (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // input channel, tdata: rx_byte[7:0]
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [scfr_pkg::BYTE_W-1:0]    req_tdata,
   // result channel
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // tdata: ctrl_byte[7:0], cmd_byte[15:8], declared_length[31:16],
   //        payload_byte[39:32], payload_index[45:40], zero[47:46]
   output logic [scfr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser: status[1:0]
   output logic [scfr_pkg::STATUS_W-1:0]       rsp_tuser,
   output logic                                rsp_tlast
);

   import scfr_pkg::*;

   // control state
   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     fill_ff, fill_in;
   logic [BYTE_W-1:0]     sum_ff, sum_in;        // 8-bit sum of all held bytes

   // header bytes and the two most recent bytes, kept beside the store
   logic [BYTE_W-1:0]     hdr_ff [HDR_BYTES];
   logic [BYTE_W-1:0]     last1_ff;               // store[fill-1]
   logic [BYTE_W-1:0]     last2_ff;               // store[fill-2]

   // frame store, one write and one registered read per cycle
   logic [BYTE_W-1:0]     store_mem [STORE_DEPTH];
   logic [BYTE_W-1:0]     rd_data_ff;

   // readout pointers
   logic [ADDR_W-1:0]     rd_idx_ff, rd_idx_in;   // next address to read
   logic [ADDR_W-1:0]     rd_pos_ff, rd_pos_in;   // address of data in rd_data_ff
   logic [ADDR_W-1:0]     end_idx_ff, end_idx_in; // last payload address

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0]     rsp_ctrl_ff, rsp_ctrl_in;
   logic [BYTE_W-1:0]     rsp_cmd_ff, rsp_cmd_in;
   logic [LEN_W-1:0]      rsp_len_ff, rsp_len_in;
   logic [BYTE_W-1:0]     rsp_pbyte_ff, rsp_pbyte_in;
   logic [PIDX_W-1:0]     rsp_pidx_ff, rsp_pidx_in;
   logic                  rsp_last_ff, rsp_last_in;

   // decoded control
   logic                  req_accept;
   logic                  rsp_free;
   logic                  overflow;
   logic                  frame_hit;
   logic                  sum_ok;
   logic                  wr_en;
   logic                  rd_en;
   logic                  load_payload;
   logic                  is_last;
   logic [BYTE_W-1:0]     sum_head;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // frame check works from the registers beside the store
   assign overflow  = (fill_ff == ADDR_W'(STORE_DEPTH - 1));
   assign frame_hit = (fill_ff >= ADDR_W'(MIN_FRAME - 1))
                      && (hdr_ff[0] == HDR_SYNC0) && (hdr_ff[1] == HDR_SYNC1)
                      && (last1_ff == TAIL_SYNC0) && (req_tdata == TAIL_SYNC1);
   // sum of all bytes but the last three: drop the two newest held bytes
   assign sum_head  = sum_ff - last1_ff - last2_ff;
   assign sum_ok    = (sum_head == last2_ff);
   assign is_last   = (rd_pos_ff == end_idx_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && !overflow && frame_hit && sum_ok) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (rsp_free && is_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_tready   = 1'b0;
      rd_en        = 1'b0;
      load_payload = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = rsp_free;
         end
         S_READ: begin
            rd_en = 1'b1;
         end
         S_LOAD: begin
            load_payload = rsp_free;
            rd_en        = rsp_free && !is_last;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign wr_en = req_accept && !overflow;

   // fill count, running sum and readout pointers
   always_comb begin
      fill_in    = fill_ff;
      sum_in     = sum_ff;
      rd_idx_in  = rd_idx_ff;
      rd_pos_in  = rd_pos_ff;
      end_idx_in = end_idx_ff;
      if (req_accept) begin
         if (overflow) begin
            fill_in = '0;
            sum_in  = '0;
         end else if (frame_hit) begin
            // frame checked: store empties whether the sum matched or not
            fill_in    = '0;
            sum_in     = '0;
            rd_idx_in  = ADDR_W'(FIRST_PAYLOAD);
            end_idx_in = fill_ff - ADDR_W'(3);
         end else begin
            fill_in = fill_ff + ADDR_W'(1);
            sum_in  = sum_ff + req_tdata;
         end
      end
      if (rd_en) begin
         rd_pos_in = rd_idx_ff;
         rd_idx_in = rd_idx_ff + ADDR_W'(1);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_ctrl_in   = rsp_ctrl_ff;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_pbyte_in  = rsp_pbyte_ff;
      rsp_pidx_in   = rsp_pidx_ff;
      rsp_last_in   = rsp_last_ff;
      if (req_accept && (overflow || (frame_hit && !sum_ok))) begin
         // single status result, every data field zero
         rsp_valid_in  = 1'b1;
         rsp_status_in = overflow ? ST_OVERFLOW : ST_SUM_ERR;
         rsp_ctrl_in   = '0;
         rsp_cmd_in    = '0;
         rsp_len_in    = '0;
         rsp_pbyte_in  = '0;
         rsp_pidx_in   = '0;
         rsp_last_in   = 1'b1;
      end else if (load_payload) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_PAYLOAD;
         rsp_ctrl_in   = hdr_ff[2];
         rsp_cmd_in    = hdr_ff[3];
         rsp_len_in    = {hdr_ff[4], hdr_ff[5]};
         rsp_pbyte_in  = rd_data_ff;
         rsp_pidx_in   = PIDX_W'(rd_pos_ff - ADDR_W'(FIRST_PAYLOAD));
         rsp_last_in   = is_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      rd_pos_ff     <= rd_pos_in;
      end_idx_ff    <= end_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ctrl_ff   <= rsp_ctrl_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_pbyte_ff  <= rsp_pbyte_in;
      rsp_pidx_ff   <= rsp_pidx_in;
      rsp_last_ff   <= rsp_last_in;
      if (wr_en) begin
         last1_ff <= req_tdata;
         last2_ff <= last1_ff;
         if (fill_ff < ADDR_W'(HDR_BYTES)) begin
            hdr_ff[fill_ff[2:0]] <= req_tdata;
         end
      end
   end

   // frame store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[fill_ff] <= req_tdata;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_idx_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FLD_W){1'b0}}, rsp_pidx_ff, rsp_pbyte_ff,
                        rsp_len_ff, rsp_cmd_ff, rsp_ctrl_ff};

`ifndef SYNTHESIS
   // a byte taken at a full store yields an overflow result next cycle
   a_overflow_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && overflow) |=> (rsp_tvalid && rsp_tuser == ST_OVERFLOW && rsp_tlast))
      else $error("overflow transaction without overflow result");

   // no input transaction during payload readout
   a_no_accept_in_readout: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("input accepted during readout");

   // status results are always single and final
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_PAYLOAD) |-> rsp_tlast)
      else $error("status result without last");

   // readout never runs past the payload end
   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> (rd_pos_ff <= end_idx_ff))
      else $error("payload read beyond frame end");

   // a completed frame empties the store
   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !overflow && frame_hit) |=> (fill_ff == '0))
      else $error("store not emptied after frame check");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// testbench for the sum-checked frame receiver: byte stream in, frame results checked out
`timescale 1ns / 100ps

module tb_top;
   import scfr_pkg::*;

   localparam int HOLD_CYCLES  = 200;   // long receiver stall to back the block up
   localparam int QUIET_LIMIT  = 5000;  // cycles with no transaction on either side
   localparam int SETTLE_WAIT  = 16;    // tail wait after the last expected result
   localparam int PHASE_ITEMS  = 8;     // least count of bytes sent per random phase

   typedef enum logic [1:0] {
      BK_RAW,        // byte as given
      BK_SUM_GOOD,   // running sum of the held bytes
      BK_SUM_BAD     // running sum plus one
   } byte_kind_type;

   typedef struct {
      byte_kind_type      kind;
      logic [BYTE_W-1:0]  value;
      bit                 typed;     // expected result typed in below
      status_type         status;
   } stim_row_type;

   typedef struct {
      status_type         status;
      logic [BYTE_W-1:0]  control;
      logic [BYTE_W-1:0]  command;
      logic [LEN_W-1:0]   length;
      logic [BYTE_W-1:0]  pbyte;
      logic [PIDX_W-1:0]  pidx;
      logic               last;
   } frame_result_type;

   logic clock      = 1'b0;
   logic reset      = 1'b1;
   logic req_tvalid = 1'b0;
   logic [BYTE_W-1:0] req_tdata = '0;
   logic rsp_tready = 1'b0;
   wire  req_tready;
   wire  rsp_tvalid;
   wire  [RSP_DATA_W-1:0] rsp_tdata;
   wire  [STATUS_W-1:0]   rsp_tuser;
   wire  rsp_tlast;

   sum_checked_frame_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state: own copy of the frame store
   logic [BYTE_W-1:0] frame_bytes [STORE_DEPTH];
   int                held_count = 0;
   frame_result_type  step_results[$];
   frame_result_type  results_due[$];

   int  send_idle_pct = 34;
   int  recv_idle_pct = 75;
   int  bytes_sent = 0;
   int  mismatch_count = 0;
   int  payload_seen = 0, sum_err_seen = 0, overflow_seen = 0, max_index_seen = 0;
   logic long_hold_armed = 1'b0;

   stim_row_type directed_rows [20];

   function automatic logic [BYTE_W-1:0] held_sum(input int count);
      logic [BYTE_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < count; i++) acc += frame_bytes[i];
      return acc;
   endfunction

   function automatic frame_result_type status_only(input status_type s);
      frame_result_type r;
      r = '{status: s, control: '0, command: '0, length: '0, pbyte: '0, pidx: '0,
            last: 1'b1};
      return r;
   endfunction

   // predictor: one accepted byte in, its results into step_results
   task automatic absorb_byte(input logic [BYTE_W-1:0] b);
      int n;
      frame_result_type r;
      step_results.delete();
      if (held_count + 1 == STORE_DEPTH) begin
         // store would fill: drop the byte and start over
         held_count = 0;
         step_results.insert(step_results.size(), status_only(ST_OVERFLOW));
         return;
      end
      frame_bytes[held_count] = b;
      held_count++;
      n = held_count;
      if (n < MIN_FRAME || frame_bytes[0] != HDR_SYNC0 || frame_bytes[1] != HDR_SYNC1 ||
          frame_bytes[n-2] != TAIL_SYNC0 || frame_bytes[n-1] != TAIL_SYNC1)
         return;
      held_count = 0;
      if (held_sum(n - 3) != frame_bytes[n-3]) begin
         step_results.insert(step_results.size(), status_only(ST_SUM_ERR));
         return;
      end
      // payload runs from byte 6 to the byte before the checksum
      for (int i = 0; i < n - 9; i++) begin
         r.status  = ST_PAYLOAD;
         r.control = frame_bytes[2];
         r.command = frame_bytes[3];
         r.length  = {frame_bytes[4], frame_bytes[5]};
         r.pbyte   = frame_bytes[FIRST_PAYLOAD + i];
         r.pidx    = PIDX_W'(i);
         r.last    = (i == n - 10);
         step_results.insert(step_results.size(), r);
      end
   endtask

   // offer one byte, wait for its transaction, then book its results
   task automatic send_item(input byte_kind_type kind, input logic [BYTE_W-1:0] value,
                            input bit typed, input status_type status);
      logic [BYTE_W-1:0] b;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      // checksum bytes are resolved now, when every earlier byte is in the store
      case (kind)
         BK_SUM_GOOD: b = held_sum(held_count);
         BK_SUM_BAD:  b = held_sum(held_count) + 8'd1;
         default:     b = value;
      endcase
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      absorb_byte(b);
      if (typed)
         results_due.insert(results_due.size(), status_only(status));
      else
         foreach (step_results[i]) results_due.insert(results_due.size(), step_results[i]);
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] value);
      send_item(BK_RAW, value, 1'b0, ST_PAYLOAD);
   endtask

   task automatic send_frame(input int plen, input bit bad_sum);
      logic [LEN_W-1:0] len;
      len = LEN_W'($urandom);
      send_byte(HDR_SYNC0);
      send_byte(HDR_SYNC1);
      send_byte(BYTE_W'($urandom));
      send_byte(BYTE_W'($urandom));
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      repeat (plen) send_byte(BYTE_W'($urandom));
      send_item(bad_sum ? BK_SUM_BAD : BK_SUM_GOOD, '0, 1'b0, ST_PAYLOAD);
      send_byte(TAIL_SYNC0);
      send_byte(TAIL_SYNC1);
   endtask

   // junk left in the store blocks every frame; fill up to the overflow drop
   task automatic flush_store();
      logic [BYTE_W-1:0] filler;
      while (held_count != 0) begin
         do filler = BYTE_W'($urandom); while (filler == TAIL_SYNC1);
         send_byte(filler);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
   endtask

   task automatic random_unit();
      int pick;
      flush_store();
      pick = $urandom_range(99);
      if (pick < 8)
         repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom));
      else if (pick < 18)
         send_frame($urandom_range(1, 8), 1'b1);
      else if (pick < 28)
         send_frame($urandom_range(9, 54), 1'b0);
      else
         send_frame($urandom_range(1, 8), 1'b0);
   endtask

   task automatic log_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // receiver: check each result transaction, then pick the next tready
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(posedge clock) begin
      frame_result_type exp;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            case (rsp_tuser)
               ST_PAYLOAD:  payload_seen++;
               ST_SUM_ERR:  sum_err_seen++;
               default:     overflow_seen++;
            endcase
            if (rsp_tuser == ST_PAYLOAD && int'(rsp_tdata[45:40]) > max_index_seen)
               max_index_seen = int'(rsp_tdata[45:40]);
            if (results_due.size() == 0) begin
               log_mismatch($sformatf("result with nothing expected, tuser=%0d tdata=%h",
                                      rsp_tuser, rsp_tdata));
            end else begin
               exp = results_due.pop_front();
               if (rsp_tuser !== exp.status || rsp_tdata[7:0] !== exp.control ||
                   rsp_tdata[15:8] !== exp.command || rsp_tdata[31:16] !== exp.length ||
                   rsp_tdata[39:32] !== exp.pbyte || rsp_tdata[45:40] !== exp.pidx ||
                   rsp_tdata[RSP_DATA_W-1:RSP_FLD_W] !== '0 || rsp_tlast !== exp.last)
                  log_mismatch({
                     $sformatf("expected st=%0d ctrl=%h cmd=%h len=%h byte=%h idx=%0d last=%0d, ",
                               exp.status, exp.control, exp.command, exp.length,
                               exp.pbyte, exp.pidx, exp.last),
                     $sformatf("got st=%0d ctrl=%h cmd=%h len=%h byte=%h idx=%0d pad=%b last=%0d",
                               rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8],
                               rsp_tdata[31:16], rsp_tdata[39:32], rsp_tdata[45:40],
                               rsp_tdata[RSP_DATA_W-1:RSP_FLD_W], rsp_tlast)});
            end
         end
         if (long_hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog: stop a run that no longer moves
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int target;
      // good frame whose control and command equal the tail bytes, tail seen
      // early while under ten bytes are held; then a frame with a bad checksum
      directed_rows = '{
         '{BK_RAW, HDR_SYNC0, 1'b0, ST_PAYLOAD},  '{BK_RAW, HDR_SYNC1, 1'b0, ST_PAYLOAD},
         '{BK_RAW, TAIL_SYNC0, 1'b0, ST_PAYLOAD}, '{BK_RAW, TAIL_SYNC1, 1'b0, ST_PAYLOAD},
         '{BK_RAW, 8'hFF, 1'b0, ST_PAYLOAD},      '{BK_RAW, 8'h00, 1'b0, ST_PAYLOAD},
         '{BK_RAW, 8'h00, 1'b0, ST_PAYLOAD},      '{BK_SUM_GOOD, 8'h00, 1'b0, ST_PAYLOAD},
         '{BK_RAW, TAIL_SYNC0, 1'b0, ST_PAYLOAD}, '{BK_RAW, TAIL_SYNC1, 1'b0, ST_PAYLOAD},
         '{BK_RAW, HDR_SYNC0, 1'b0, ST_PAYLOAD},  '{BK_RAW, HDR_SYNC1, 1'b0, ST_PAYLOAD},
         '{BK_RAW, 8'hFF, 1'b0, ST_PAYLOAD},      '{BK_RAW, 8'h00, 1'b0, ST_PAYLOAD},
         '{BK_RAW, 8'h00, 1'b0, ST_PAYLOAD},      '{BK_RAW, 8'hFF, 1'b0, ST_PAYLOAD},
         '{BK_RAW, 8'hFF, 1'b0, ST_PAYLOAD},      '{BK_SUM_BAD, 8'h00, 1'b0, ST_PAYLOAD},
         '{BK_RAW, TAIL_SYNC0, 1'b0, ST_PAYLOAD}, '{BK_RAW, TAIL_SYNC1, 1'b1, ST_SUM_ERR}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part runs with the sender idling less than the receiver
      foreach (directed_rows[i])
         send_item(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].typed,
                   directed_rows[i].status);
      // fill to one below the store depth with non-frame bytes, then overflow
      for (int i = 0; i < STORE_DEPTH - 1; i++) send_byte(i[0] ? 8'hAA : 8'h55);
      send_item(BK_RAW, 8'h3C, 1'b1, ST_OVERFLOW);
      drain();

      for (int phase = 1; phase < 3; phase++) begin
         case (phase)
            1: begin send_idle_pct = 75; recv_idle_pct = 34; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (phase == 2) begin
            // receiver stalls while a full-size frame comes in
            flush_store();
            long_hold_armed <= 1'b1;
            send_frame(STORE_DEPTH - 1 - MIN_FRAME + 1, 1'b0);
         end
         target = bytes_sent + PHASE_ITEMS;
         while (bytes_sent < target) random_unit();
         drain();
      end

      repeat (SETTLE_WAIT) @(posedge clock);
      $display("covered %0d bytes; results %0d payload, %0d sum error, %0d overflow",
               bytes_sent, payload_seen, sum_err_seen, overflow_seen);
      $display("highest payload index %0d, %0d mismatches, long output stall applied",
               max_index_seen, mismatch_count);
      if (mismatch_count == 0 && results_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/scfr_pkg.sv
rtl/core/sum_checked_frame_receiver.sv
sim/tb_top.sv
